>>> rtl/strf_pkg.sv
// shared types and constants for the stack trace record filter
package strf_pkg;

	localparam int unsigned WORD_W       = 64;
	localparam int unsigned BYTES_W      = 4;
	localparam int unsigned DROP_W       = 32;
	localparam int unsigned REG_IDX_W    = 3;
	localparam int unsigned ADDR_CNT_W   = 3;
	localparam int unsigned PADDR_W      = 6;
	localparam int unsigned PDATA_W      = 64;
	localparam int unsigned DEF_MAX_DEPTH   = 62;
	localparam int unsigned DEF_NUM_MATCH   = 6;
	localparam logic [BYTES_W-1:0] FULL_WORD_BYTES = 4'd8;

	// register map, one 64-bit register every 8 bytes
	localparam logic [REG_IDX_W-1:0] REG_ADDRESS_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MATCH_BASE    = 3'd1;

	typedef enum logic {
		CMD_ONE,
		CMD_REC
	} cmd_kind_t;

	// one work item for the back end
	typedef struct packed {
		cmd_kind_t            kind;
		logic [WORD_W-1:0]    w0;
		logic [WORD_W-1:0]    w1;
		logic [BYTES_W-1:0]   nbytes;
		logic                 ovf;
		logic [DROP_W-1:0]    dropped;
	} cmd_t;

endpackage

>>> rtl/stack_trace_record_filter_top.sv
// top level of the stack trace record filter: config registers and wiring
//
// Input channel (in_valid/in_ready, in_word, in_bytes) takes one 64-bit
// stream word per transaction. Output channel (out_valid/out_ready)
// delivers the filtered words; last_of_run marks the final word caused by
// one input word, overflow flags words of a record deeper than MAX_DEPTH,
// dropped_total is the saturating count of dropped records.
// Header, deep-record and trailer words pass through the queue and the
// output register one word per cycle, unless stalled. Record counters are
// collected one a cycle while in_ready is high; a kept record then plays
// out of the counter buffer: count and depth words one a cycle unless
// stalled, each counter by a buffer read, then the output register.
// During playout the front takes count and depth but not counter words.
// When the receiver stalls, the output register holds, the two entry
// command queue fills, and in_ready drops.
// Reset clears the parse state, the queue, the dropped total and the config
// registers; no clearing pass is needed. Configure through the APB port
// (64-bit registers at 8-byte spacing) only while the block is idle.
module stack_trace_record_filter_top #(
	parameter int unsigned MAX_DEPTH           = strf_pkg::DEF_MAX_DEPTH,
	parameter int unsigned NUM_MATCH_ADDRESSES = strf_pkg::DEF_NUM_MATCH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [strf_pkg::PADDR_W-1:0]        paddr,
	input  logic [strf_pkg::PDATA_W-1:0]        pwdata,
	output logic [strf_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [strf_pkg::WORD_W-1:0]         in_word,
	input  logic [strf_pkg::BYTES_W-1:0]        in_bytes,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [strf_pkg::WORD_W-1:0]         out_word,
	output logic [strf_pkg::BYTES_W-1:0]        out_bytes,
	output logic                                last_of_run,
	output logic                                overflow,
	output logic [strf_pkg::DROP_W-1:0]         dropped_total
);

	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [strf_pkg::ADDR_CNT_W-1:0] addr_count_q;
	logic [strf_pkg::WORD_W-1:0]     match_addr_q [NUM_MATCH_ADDRESSES];
	logic [strf_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                            cfg_write;

	logic                            push;
	strf_pkg::cmd_t                  push_cmd;
	logic                            q_full;
	logic                            pop;
	strf_pkg::cmd_t                  head;
	logic                            q_empty;
	logic                            rec_done;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [strf_pkg::WORD_W-1:0]     ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [strf_pkg::WORD_W-1:0]     ram_rdata;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[strf_pkg::PADDR_W-1:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_count_q <= '0;
			for (int i = 0; i < NUM_MATCH_ADDRESSES; i++) begin
				match_addr_q[i] <= '0;
			end
		end else if (cfg_write) begin
			if (reg_idx == strf_pkg::REG_ADDRESS_COUNT) begin
				addr_count_q <= pwdata[strf_pkg::ADDR_CNT_W-1:0];
			end
			for (int i = 0; i < NUM_MATCH_ADDRESSES; i++) begin
				if (reg_idx == strf_pkg::REG_IDX_W'(strf_pkg::REG_MATCH_BASE + i)) begin
					match_addr_q[i] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == strf_pkg::REG_ADDRESS_COUNT) begin
			prdata = strf_pkg::PDATA_W'(addr_count_q);
		end
		for (int i = 0; i < NUM_MATCH_ADDRESSES; i++) begin
			if (reg_idx == strf_pkg::REG_IDX_W'(strf_pkg::REG_MATCH_BASE + i)) begin
				prdata = match_addr_q[i];
			end
		end
	end

	strf_front #(
		.MAX_DEPTH           (MAX_DEPTH),
		.NUM_MATCH_ADDRESSES (NUM_MATCH_ADDRESSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.in_bytes   (in_bytes),
		.addr_count (addr_count_q),
		.match_addr (match_addr_q),
		.q_full     (q_full),
		.rec_done   (rec_done),
		.push       (push),
		.push_cmd   (push_cmd),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	strf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	strf_ram #(
		.WIDTH (strf_pkg::WORD_W),
		.DEPTH (MAX_DEPTH)
	) u_pc_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	strf_back #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.rec_done      (rec_done),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.out_bytes     (out_bytes),
		.last_of_run   (last_of_run),
		.overflow      (overflow),
		.dropped_total (dropped_total)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command popped from an empty queue");

	// the buffer must not be refilled while a kept record is still played out
	a_no_write_during_playout: assert property (@(posedge clk) disable iff (!arst_n)
		rec_done |-> !ram_we)
		else $error("counter buffer written during record playout");

endmodule

>>> rtl/strf_ram.sv
// generic single write port ram with registered read
module strf_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 62,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/strf_queue.sv
// two entry command queue between front and back
module strf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  strf_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output strf_pkg::cmd_t head,
	output logic           empty
);

	strf_pkg::cmd_t entries_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);

endmodule

>>> rtl/strf_front.sv
// front end: parses the stream, buffers counters, decides keep or drop
module strf_front #(
	parameter int unsigned MAX_DEPTH           = strf_pkg::DEF_MAX_DEPTH,
	parameter int unsigned NUM_MATCH_ADDRESSES = strf_pkg::DEF_NUM_MATCH,
	localparam int unsigned DW = $clog2(MAX_DEPTH + 1),
	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [strf_pkg::WORD_W-1:0]         in_word,
	input  logic [strf_pkg::BYTES_W-1:0]        in_bytes,
	input  logic [strf_pkg::ADDR_CNT_W-1:0]     addr_count,
	input  logic [strf_pkg::WORD_W-1:0]         match_addr [NUM_MATCH_ADDRESSES],
	input  logic                                q_full,
	input  logic                                rec_done,
	output logic                                push,
	output strf_pkg::cmd_t                      push_cmd,
	output logic                                ram_we,
	output logic [AW-1:0]                       ram_waddr,
	output logic [strf_pkg::WORD_W-1:0]         ram_wdata
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR_MORE,
		PH_COUNT,
		PH_DEPTH,
		PH_PCS,
		PH_DEEP,
		PH_TRAILER
	} phase_t;

	phase_t                              phase_q;
	logic [strf_pkg::WORD_W-1:0]         hdr_left_q;
	logic [strf_pkg::WORD_W-1:0]         count_q;
	logic [strf_pkg::WORD_W-1:0]         depth_q;
	logic [DW-1:0]                       seen_q;
	logic                                match_q;
	logic                                rec_busy_q;
	logic [strf_pkg::DROP_W-1:0]         dropped_q;

	logic                                accept;
	logic                                hit;
	logic                                pc_last;
	logic                                is_term;
	logic [strf_pkg::ADDR_CNT_W-1:0]     eff_count;

	assign in_ready = !q_full && !(rec_busy_q && phase_q == PH_PCS);
	assign accept   = in_valid && in_ready;

	assign eff_count = (addr_count > strf_pkg::ADDR_CNT_W'(NUM_MATCH_ADDRESSES)) ?
		strf_pkg::ADDR_CNT_W'(NUM_MATCH_ADDRESSES) : addr_count;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < NUM_MATCH_ADDRESSES; i++) begin
			if ((strf_pkg::ADDR_CNT_W'(i) < eff_count) && (match_addr[i] == in_word)) begin
				hit = 1'b1;
			end
		end
	end

	// depth is at most MAX_DEPTH while counters are collected
	assign pc_last = (DW'(seen_q + 1'b1) == depth_q[DW-1:0]);
	assign is_term = (count_q == '0) && (depth_q == strf_pkg::WORD_W'(1)) && (in_word == '0);

	assign ram_we    = accept && (phase_q == PH_PCS);
	assign ram_waddr = seen_q[AW-1:0];
	assign ram_wdata = in_word;

	always_comb begin
		push             = 1'b0;
		push_cmd.kind    = strf_pkg::CMD_ONE;
		push_cmd.w0      = in_word;
		push_cmd.w1      = in_word;
		push_cmd.nbytes  = strf_pkg::FULL_WORD_BYTES;
		push_cmd.ovf     = 1'b0;
		push_cmd.dropped = dropped_q;
		if (accept) begin
			unique case (phase_q)
				PH_HDR0, PH_HDR1, PH_HDR_MORE: begin
					push = 1'b1;
				end
				PH_COUNT: begin
					push = 1'b0;
				end
				PH_DEPTH: begin
					push_cmd.kind = strf_pkg::CMD_REC;
					push_cmd.w0   = count_q;
					push_cmd.w1   = in_word;
					if (in_word == '0) begin
						push = 1'b1;
					end else if (in_word > strf_pkg::WORD_W'(MAX_DEPTH)) begin
						push         = 1'b1;
						push_cmd.ovf = 1'b1;
					end
				end
				PH_PCS: begin
					push_cmd.kind = strf_pkg::CMD_REC;
					push_cmd.w0   = count_q;
					push_cmd.w1   = depth_q;
					if (pc_last && (is_term || !(match_q || hit))) begin
						push = 1'b1;
					end
				end
				PH_DEEP: begin
					push         = 1'b1;
					push_cmd.ovf = 1'b1;
				end
				PH_TRAILER: begin
					push = (in_bytes != '0);
					if (in_bytes < strf_pkg::FULL_WORD_BYTES) begin
						push_cmd.nbytes = in_bytes;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			hdr_left_q <= '0;
			count_q    <= '0;
			depth_q    <= '0;
			seen_q     <= '0;
			match_q    <= 1'b0;
			rec_busy_q <= 1'b0;
			dropped_q  <= '0;
		end else begin
			if (rec_done) begin
				rec_busy_q <= 1'b0;
			end
			if (accept) begin
				unique case (phase_q)
					PH_HDR0: begin
						phase_q <= PH_HDR1;
					end
					PH_HDR1: begin
						hdr_left_q <= in_word;
						phase_q    <= (in_word == '0) ? PH_COUNT : PH_HDR_MORE;
					end
					PH_HDR_MORE: begin
						hdr_left_q <= hdr_left_q - 1'b1;
						if (hdr_left_q == strf_pkg::WORD_W'(1)) begin
							phase_q <= PH_COUNT;
						end
					end
					PH_COUNT: begin
						count_q <= in_word;
						phase_q <= PH_DEPTH;
					end
					PH_DEPTH: begin
						depth_q <= in_word;
						seen_q  <= '0;
						match_q <= 1'b0;
						if (in_word == '0) begin
							phase_q <= PH_COUNT;
						end else if (in_word > strf_pkg::WORD_W'(MAX_DEPTH)) begin
							phase_q <= PH_DEEP;
						end else begin
							phase_q <= PH_PCS;
						end
					end
					PH_PCS: begin
						seen_q  <= DW'(seen_q + 1'b1);
						match_q <= match_q || hit;
						if (pc_last) begin
							if (is_term) begin
								phase_q    <= PH_TRAILER;
								rec_busy_q <= 1'b1;
							end else if (match_q || hit) begin
								phase_q <= PH_COUNT;
								if (dropped_q != '1) begin
									dropped_q <= dropped_q + 1'b1;
								end
							end else begin
								phase_q    <= PH_COUNT;
								rec_busy_q <= 1'b1;
							end
						end
					end
					PH_DEEP: begin
						depth_q <= depth_q - 1'b1;
						if (depth_q == strf_pkg::WORD_W'(1)) begin
							phase_q <= PH_COUNT;
						end
					end
					PH_TRAILER: begin
						phase_q <= PH_TRAILER;
					end
					default: begin
						phase_q <= PH_HDR0;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/strf_back.sv
// back end: plays out queued commands, reading kept counters from the buffer
module strf_back #(
	parameter int unsigned MAX_DEPTH = strf_pkg::DEF_MAX_DEPTH,
	localparam int unsigned DW = $clog2(MAX_DEPTH + 1),
	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  strf_pkg::cmd_t                 head,
	input  logic                           q_empty,
	output logic                           pop,
	output logic                           rec_done,
	output logic                           ram_re,
	output logic [AW-1:0]                  ram_raddr,
	input  logic [strf_pkg::WORD_W-1:0]    ram_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [strf_pkg::WORD_W-1:0]    out_word,
	output logic [strf_pkg::BYTES_W-1:0]   out_bytes,
	output logic                           last_of_run,
	output logic                           overflow,
	output logic [strf_pkg::DROP_W-1:0]    dropped_total
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_W1,
		S_RD,
		S_PC
	} state_t;

	state_t                              state_q;
	logic [strf_pkg::WORD_W-1:0]         w1_q;
	logic                                ovf_q;
	logic [DW-1:0]                       n_q;
	logic [DW-1:0]                       j_q;
	logic                                out_valid_q;
	logic [strf_pkg::WORD_W-1:0]         out_word_q;
	logic [strf_pkg::BYTES_W-1:0]        out_bytes_q;
	logic                                out_last_q;
	logic                                out_ovf_q;
	logic [strf_pkg::DROP_W-1:0]         out_drop_q;

	logic                                out_free;
	logic                                out_load;
	logic                                pc_last;

	assign out_free  = !out_valid_q || out_ready;
	assign pc_last   = (DW'(j_q + 1'b1) == n_q);
	assign pop       = (state_q == S_IDLE) && !q_empty && out_free;
	assign out_load  = pop || (((state_q == S_W1) || (state_q == S_PC)) && out_free);
	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = j_q[AW-1:0];
	assign rec_done  = (state_q == S_PC) && out_free && pc_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w1_q        <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_bytes_q <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_drop_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						out_word_q  <= head.w0;
						out_bytes_q <= head.nbytes;
						out_ovf_q   <= head.ovf;
						out_drop_q  <= head.dropped;
						w1_q        <= head.w1;
						ovf_q       <= head.ovf;
						// deep records carry no buffered counters
						n_q         <= head.ovf ? '0 : head.w1[DW-1:0];
						j_q         <= '0;
						if (head.kind == strf_pkg::CMD_REC) begin
							out_last_q <= 1'b0;
							state_q    <= S_W1;
						end else begin
							out_last_q <= 1'b1;
						end
					end
				end
				S_W1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= w1_q;
						out_bytes_q <= strf_pkg::FULL_WORD_BYTES;
						out_ovf_q   <= ovf_q;
						out_last_q  <= (n_q == '0);
						state_q     <= (n_q == '0) ? S_IDLE : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_PC;
				end
				S_PC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= ram_rdata;
						out_bytes_q <= strf_pkg::FULL_WORD_BYTES;
						out_ovf_q   <= 1'b0;
						out_last_q  <= pc_last;
						j_q         <= DW'(j_q + 1'b1);
						state_q     <= pc_last ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_word      = out_word_q;
	assign out_bytes     = out_bytes_q;
	assign last_of_run   = out_last_q;
	assign overflow      = out_ovf_q;
	assign dropped_total = out_drop_q;

endmodule
